// File: design/rgb5a3_tile_converter_core_assert.svh
// Assertion macros used by the checker of the RGB5A3 tile converter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RGB5A3_TILE_CONVERTER_CORE_ASSERT_SVH
`define RGB5A3_TILE_CONVERTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define R5A3TC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define R5A3TC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/r5a3tc_pkg.sv
`timescale 1ns / 1ps

package r5a3tc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int TILE_SIDE   = 4;
    localparam int STORE_DEPTH = MAX_WIDTH * TILE_SIDE;

    localparam int DIM_W    = 11;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SUB_W    = $clog2(TILE_SIDE);
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int TIDX_W   = 2 * SUB_W;
    localparam int TEXEL_W  = 16;
    localparam int WORD_W   = 32;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_16BIT = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hE0;

    typedef struct packed {
        logic [COL_W-1:0] w_m1;
        logic [ROW_W-1:0] h_m1;
        logic             src16;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-SUB_W-1:0] tile_col;
        logic [ROW_W-SUB_W-1:0] tile_row;
        logic                   last_col;
        logic                   last_row;
    } tile_cmd_t;

    function automatic logic [TEXEL_W-1:0] encode_texel(input logic [WORD_W-1:0] word,
                                                        input logic src16);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        if (src16)
        begin
            r = {word[14:10], 3'b000};
            g = {word[9:5], 3'b000};
            b = {word[4:0], 3'b000};
            a = word[15] ? 8'hFF : 8'h00;
        end
        else
        begin
            r = word[7:0];
            g = word[15:8];
            b = word[23:16];
            a = word[31:24];
        end
        if (a >= ALPHA_OPAQUE)
            return {1'b1, r[7:3], g[7:3], b[7:3]};
        else
            return {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
    endfunction

endpackage

// File: design/rgb5a3_tile_converter_core.sv
`timescale 1ns / 1ps

// RGB5A3 tile converter: source pixels go in on the pixel channel in raster
// order, texels come out on the texel channel in 4x4 tile order.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The APB port sets image width, image height and the source format; write it
// only while no image is in progress. pready is always high.
// A pixel item is taken every cycle unless the input register is full while
// a tile is being read. When the last pixel of a tile arrives (bottom-right,
// clipped at the image edges), sixteen texels follow at one per cycle while
// the receiver does not stall, via the read and texel output registers;
// tile_end marks the sixteenth, image_end the last texel of the image. The
// pixel side stalls for the tile's reads: the strip store has one read port.
// When the receiver stalls, the texel output register holds and reads stop;
// the pixel side stalls once its input register is full.
// Reset clears the position counters and all valids and sets width and height
// to 1 and the source format to 32-bit; the strip store is not cleared.
module rgb5a3_tile_converter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [r5a3tc_pkg::PADDR_W-1:0]  paddr,
    input  logic [r5a3tc_pkg::PDATA_W-1:0]  pwdata,
    output logic [r5a3tc_pkg::PDATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [r5a3tc_pkg::WORD_W-1:0]   pixel_word,
    output logic                            texel_valid,
    input  logic                            texel_stall,
    output logic [r5a3tc_pkg::TEXEL_W-1:0]  texel,
    output logic                            tile_end,
    output logic                            image_end
);
    import r5a3tc_pkg::*;

    cfg_t                cfg;
    tile_cmd_t           cmd;
    logic                busy;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [TEXEL_W-1:0]  rd_data;

    logic [COL_W-1:0]    col_cnt_reg;
    logic [COL_W-1:0]    col_cnt_next;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [ROW_W-1:0]    row_cnt_next;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;

    logic                s1_valid_reg;
    logic [WORD_W-1:0]   s1_word_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;

    logic                accept;
    logic                s1_advance;
    logic                last_col;
    logic                last_row;
    logic                tile_hit;

    r5a3tc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_advance  = s1_valid_reg && !busy;
    assign pixel_stall = s1_valid_reg && busy;
    assign accept      = pixel_valid && !pixel_stall;

    // A position beyond the current size (after a resize) restarts the image.
    always_comb
    begin
        if (col_cnt_reg > cfg.w_m1 || row_cnt_reg > cfg.h_m1)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else
        begin
            cur_col = col_cnt_reg;
            cur_row = row_cnt_reg;
        end

        if (cur_col == cfg.w_m1)
        begin
            col_cnt_next = '0;
            row_cnt_next = (cur_row == cfg.h_m1) ? '0 : cur_row + ROW_W'(1);
        end
        else
        begin
            col_cnt_next = cur_col + COL_W'(1);
            row_cnt_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= pixel_word;
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
        end
    end

    assign last_col = (s1_col_reg == cfg.w_m1);
    assign last_row = (s1_row_reg == cfg.h_m1);
    assign tile_hit = ((s1_col_reg[SUB_W-1:0] == {SUB_W{1'b1}}) || last_col) &&
                      ((s1_row_reg[SUB_W-1:0] == {SUB_W{1'b1}}) || last_row);

    assign cmd.tile_col = s1_col_reg[COL_W-1:SUB_W];
    assign cmd.tile_row = s1_row_reg[ROW_W-1:SUB_W];
    assign cmd.last_col = last_col;
    assign cmd.last_row = last_row;

    r5a3tc_strip_store u_strip_store (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr ({s1_row_reg[SUB_W-1:0], s1_col_reg}),
        .wr_data (encode_texel(s1_word_reg, cfg.src16)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    r5a3tc_tile_reader u_tile_reader (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (s1_advance && tile_hit),
        .cmd         (cmd),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel       (texel),
        .tile_end    (tile_end),
        .image_end   (image_end)
    );

endmodule

// File: design/r5a3tc_cfg_regs.sv
`timescale 1ns / 1ps

module r5a3tc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [r5a3tc_pkg::PADDR_W-1:0]  paddr,
    input  logic [r5a3tc_pkg::PDATA_W-1:0]  pwdata,
    output logic [r5a3tc_pkg::PDATA_W-1:0]  prdata,
    output logic                            pready,
    output r5a3tc_pkg::cfg_t                cfg
);
    import r5a3tc_pkg::*;

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic                 src16_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            src16_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_SOURCE_16BIT: src16_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_SOURCE_16BIT: prdata = PDATA_W'(src16_reg);
            default:          prdata = '0;
        endcase
    end

    // Dimensions are clamped to 1..max and kept as the index of the last column or row.
    always_comb
    begin
        if (width_reg == '0)
            cfg.w_m1 = '0;
        else if (width_reg > DIM_W'(MAX_WIDTH))
            cfg.w_m1 = COL_W'(MAX_WIDTH - 1);
        else
            cfg.w_m1 = COL_W'(width_reg - DIM_W'(1));

        if (height_reg == '0)
            cfg.h_m1 = '0;
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            cfg.h_m1 = ROW_W'(MAX_HEIGHT - 1);
        else
            cfg.h_m1 = ROW_W'(height_reg - DIM_W'(1));

        cfg.src16 = src16_reg;
    end

endmodule

// File: design/r5a3tc_strip_store.sv
`timescale 1ns / 1ps

module r5a3tc_strip_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [r5a3tc_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [r5a3tc_pkg::TEXEL_W-1:0]  wr_data,
    input  logic                            rd_en,
    input  logic [r5a3tc_pkg::ADDR_W-1:0]   rd_addr,
    output logic [r5a3tc_pkg::TEXEL_W-1:0]  rd_data
);
    import r5a3tc_pkg::*;

    logic [TEXEL_W-1:0] mem [0:STORE_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// File: design/r5a3tc_tile_reader.sv
`timescale 1ns / 1ps

module r5a3tc_tile_reader (
    input  logic                            clk,
    input  logic                            rst_n,
    input  r5a3tc_pkg::cfg_t                cfg,
    input  logic                            start,
    input  r5a3tc_pkg::tile_cmd_t           cmd,
    output logic                            busy,
    output logic                            rd_en,
    output logic [r5a3tc_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [r5a3tc_pkg::TEXEL_W-1:0]  rd_data,
    output logic                            texel_valid,
    input  logic                            texel_stall,
    output logic [r5a3tc_pkg::TEXEL_W-1:0]  texel,
    output logic                            tile_end,
    output logic                            image_end
);
    import r5a3tc_pkg::*;

    logic                busy_reg;
    logic [TIDX_W-1:0]   idx_reg;
    tile_cmd_t           cmd_reg;
    logic                rd_valid_reg;
    logic                rd_pad_reg;
    logic                rd_tile_end_reg;
    logic                rd_img_end_reg;
    logic                out_valid_reg;
    logic [TEXEL_W-1:0]  out_texel_reg;
    logic                out_tile_end_reg;
    logic                out_img_end_reg;

    logic                issue;
    logic                rd_move;
    logic                last_idx;
    logic [COL_W-1:0]    src_x;
    logic [ROW_W-1:0]    src_y;
    logic                pad;

    // Tile origins are multiples of the tile side, so the offset is simply appended.
    assign src_x    = {cmd_reg.tile_col, idx_reg[SUB_W-1:0]};
    assign src_y    = {cmd_reg.tile_row, idx_reg[TIDX_W-1:SUB_W]};
    assign pad      = (src_x > cfg.w_m1) || (src_y > cfg.h_m1);
    assign last_idx = (idx_reg == {TIDX_W{1'b1}});

    assign rd_move  = rd_valid_reg && (!out_valid_reg || !texel_stall);
    assign issue    = busy_reg && (!rd_valid_reg || rd_move);
    assign rd_en    = issue;
    assign rd_addr  = {idx_reg[TIDX_W-1:SUB_W], src_x};
    assign busy     = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + TIDX_W'(1);
                if (last_idx)
                    busy_reg <= 1'b0;
            end

            if (issue)
                rd_valid_reg <= 1'b1;
            else if (rd_move)
                rd_valid_reg <= 1'b0;

            if (rd_move)
                out_valid_reg <= 1'b1;
            else if (!texel_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
            cmd_reg <= cmd;
        if (issue)
        begin
            rd_pad_reg      <= pad;
            rd_tile_end_reg <= last_idx;
            rd_img_end_reg  <= last_idx && cmd_reg.last_col && cmd_reg.last_row;
        end
        if (rd_move)
        begin
            out_texel_reg    <= rd_pad_reg ? '0 : rd_data;
            out_tile_end_reg <= rd_tile_end_reg;
            out_img_end_reg  <= rd_img_end_reg;
        end
    end

    assign texel_valid = out_valid_reg;
    assign texel       = out_texel_reg;
    assign tile_end    = out_tile_end_reg;
    assign image_end   = out_img_end_reg;

endmodule

// File: design/r5a3tc_checker.sv
`timescale 1ns / 1ps

`include "rgb5a3_tile_converter_core_assert.svh"

module r5a3tc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            texel_valid,
    input logic                            texel_stall,
    input logic [r5a3tc_pkg::TEXEL_W-1:0]  texel,
    input logic                            tile_end,
    input logic                            image_end
);
    import r5a3tc_pkg::*;

    logic [TIDX_W-1:0] texel_cnt_reg;
    logic              texel_taken;
    logic              cnt_at_last;

    assign texel_taken = texel_valid && !texel_stall;
    assign cnt_at_last = (texel_cnt_reg == {TIDX_W{1'b1}});

    // Texels always leave in whole tiles, so a running count locates tile_end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            texel_cnt_reg <= '0;
        else if (texel_taken)
            texel_cnt_reg <= texel_cnt_reg + TIDX_W'(1);
    end

    `R5A3TC_ASSERT_NEXT(a_texel_hold, texel_valid && texel_stall,
        texel_valid && $stable(texel) && $stable(tile_end) && $stable(image_end),
        "stalled texel item changed or dropped")

    `R5A3TC_ASSERT_NOW(a_tile_end_pos, texel_valid, tile_end == cnt_at_last,
        "tile_end not on the sixteenth texel of a tile")

    `R5A3TC_ASSERT_NOW(a_image_end_tile, texel_valid && image_end, tile_end,
        "image_end without tile_end")

endmodule

bind rgb5a3_tile_converter_core r5a3tc_checker u_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import r5a3tc_pkg::*;

    typedef struct {
        logic [TEXEL_W-1:0] texel;
        logic               tile_end;
        logic               image_end;
    } texel_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_stall;
    logic [WORD_W-1:0]    pixel_word = '0;
    logic                 texel_valid;
    logic                 texel_stall = 1'b0;
    logic [TEXEL_W-1:0]   texel;
    logic                 tile_end;
    logic                 image_end;

    logic [WORD_W-1:0]    pixel_queue [$];
    texel_item_t          texel_queue [$];
    int                   pixels_queued = 0;
    int                   pixels_taken = 0;
    int                   fail_count = 0;
    int                   sender_idle_pct = 33;
    int                   receiver_idle_pct = 45;

    // Predictor state: configuration, raster position and the four-row strip.
    logic [DIM_W-1:0]     cfg_width = 11'd1;
    logic [DIM_W-1:0]     cfg_height = 11'd1;
    logic                 cfg_src16 = 1'b0;
    int                   col_pos = 0;
    int                   row_pos = 0;
    logic [TEXEL_W-1:0]   strip_mem [STORE_DEPTH];

    rgb5a3_tile_converter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel       (texel),
        .tile_end    (tile_end),
        .image_end   (image_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [TEXEL_W-1:0] to_rgb5a3(input logic [WORD_W-1:0] word,
                                                     input logic src16);
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
        logic [7:0] alp;
        if (src16)
        begin
            red = {word[14:10], 3'b000};
            grn = {word[9:5], 3'b000};
            blu = {word[4:0], 3'b000};
            alp = {8{word[15]}};
        end
        else
        begin
            {alp, blu, grn, red} = word;
        end
        if (alp >= 8'hE0)
            return {1'b1, red[7:3], grn[7:3], blu[7:3]};
        return {1'b0, alp[7:5], red[7:4], grn[7:4], blu[7:4]};
    endfunction

    // Stores one pixel and, when it closes a tile, queues that tile's texels.
    task automatic tile_predict(input logic [WORD_W-1:0] word);
        int          w;
        int          h;
        int          col;
        int          row;
        int          sub;
        int          n;
        bit          last_col;
        bit          last_row;
        texel_item_t item;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        sub = row % TILE_SIDE;
        strip_mem[sub * MAX_WIDTH + col] = to_rgb5a3(word, cfg_src16);
        last_col = (col == w - 1);
        last_row = (row == h - 1);
        if ((col % TILE_SIDE == TILE_SIDE - 1 || last_col) &&
            (sub == TILE_SIDE - 1 || last_row))
        begin
            n = 0;
            for (int y = 0; y < TILE_SIDE; y++)
            begin
                for (int x = 0; x < TILE_SIDE; x++)
                begin
                    item.texel = '0;
                    if (col - col % TILE_SIDE + x < w && row - sub + y < h)
                        item.texel = strip_mem[y * MAX_WIDTH + col - col % TILE_SIDE + x];
                    item.tile_end = (n == 15);
                    item.image_end = (n == 15) && last_col && last_row;
                    texel_queue.push_back(item);
                    n++;
                end
            end
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row + 1;
        end
        else
            col_pos = col + 1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pixel_valid <= 1'b0;
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                tile_predict(pixel_word);
                pixels_taken++;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    pixel_valid <= 1'b1;
                    pixel_word <= pixel_queue.pop_front();
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        texel_item_t want;
        if (!rst_n)
            texel_stall <= 1'b0;
        else
        begin
            if (texel_valid && !texel_stall)
            begin
                if (texel_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected texel %h tile_end %b image_end %b",
                                 texel, tile_end, image_end);
                end
                else
                begin
                    want = texel_queue.pop_front();
                    if (texel !== want.texel || tile_end !== want.tile_end ||
                        image_end !== want.image_end)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("texel %h tile_end %b image_end %b, expected %h %b %b",
                                     texel, tile_end, image_end,
                                     want.texel, want.tile_end, want.image_end);
                    end
                end
            end
            texel_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_SOURCE_16BIT: cfg_src16 = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic push_pixel(input logic [WORD_W-1:0] word);
        pixel_queue.push_back(word);
        pixels_queued++;
    endtask

    // Half of the time alpha is forced to DF, E0 (the opaque threshold), FF or 00.
    task automatic queue_pixels(input int count);
        logic [WORD_W-1:0] word;
        for (int i = 0; i < count; i++)
        begin
            word = $urandom;
            case ($urandom_range(7))
                0: word[31:24] = 8'hDF;
                1: word[31:24] = 8'hE0;
                2: word[31:24] = 8'hFF;
                3: word[31:24] = 8'h00;
                default: ;
            endcase
            push_pixel(word);
        end
    endtask

    // Lets the pixel queue drain and every pending texel arrive, then lets any pixel
    // still in flight inside the block settle.
    task automatic wait_idle();
        while (pixels_taken != pixels_queued)
            @(negedge clk);
        while (texel_queue.size() != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int random_count;
        int img_w;
        int img_h;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the image is 1x1, so every pixel closes a padded tile.
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0000_0000);
        push_pixel(32'hE012_3456);
        push_pixel(32'hDFFE_DCBA);
        wait_idle();

        // 1555 source: high half is ignored, bit 15 selects the opaque form.
        apb_write(REG_SOURCE_16BIT, 32'd1);
        push_pixel(32'hFFFF_7FFF);
        push_pixel(32'h1234_8000);
        wait_idle();

        // Widest and tallest images, cut short; the next size change restarts
        // the position counters.
        apb_write(REG_SOURCE_16BIT, 32'd0);
        apb_write(REG_IMAGE_WIDTH, 32'd1024);
        apb_write(REG_IMAGE_HEIGHT, 32'd1);
        queue_pixels(4);
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, 32'd1);
        apb_write(REG_IMAGE_HEIGHT, 32'd1024);
        queue_pixels(4);
        wait_idle();

        // Out-of-range sizes clamp to the limits.
        apb_write(REG_IMAGE_WIDTH, 32'd2047);
        apb_write(REG_IMAGE_HEIGHT, 32'd0);
        queue_pixels(4);
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, 32'd0);
        queue_pixels(2);
        wait_idle();

        random_count = 0;
        while (random_count < 330)
        begin
            if (random_count >= 220)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            else if (random_count >= 110)
            begin
                sender_idle_pct = 45;
                receiver_idle_pct = 33;
            end
            if ($urandom_range(5) == 0)
            begin
                img_w = $urandom_range(13, 32);
                img_h = $urandom_range(1, 4);
            end
            else
            begin
                img_w = $urandom_range(1, 12);
                img_h = $urandom_range(1, 10);
            end
            apb_write(REG_IMAGE_WIDTH, img_w);
            apb_write(REG_IMAGE_HEIGHT, img_h);
            apb_write(REG_SOURCE_16BIT, $urandom_range(1));
            repeat ($urandom_range(1, 2))
            begin
                queue_pixels(img_w * img_h);
                random_count += img_w * img_h;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/r5a3tc_pkg.sv
design/r5a3tc_cfg_regs.sv
design/r5a3tc_strip_store.sv
design/r5a3tc_tile_reader.sv
design/rgb5a3_tile_converter_core.sv
design/r5a3tc_checker.sv
bench/tb.sv
